>>> design/wipf_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the wildcard IP filter table.
// Depends on nothing; every other file of the block imports it.

package wipf_pkg;

   localparam int OCTET_WIDTH     = 8;
   localparam int ADDR_WIDTH      = 4 * OCTET_WIDTH;
   localparam int WILD_WIDTH      = 4;
   localparam int FUNC_WIDTH      = 2;
   localparam int COUNT_OUT_WIDTH = 7;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_CHECK  = 2'd2
   } func_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_busy;
   } dp_status_type;

   // Bits that take part in a compare; octet a sits in the top byte.
   function automatic logic [ADDR_WIDTH-1:0] care_mask(input logic [WILD_WIDTH-1:0] wild);
      logic [ADDR_WIDTH-1:0] mask;
      mask = '0;
      for (int i = 0; i < WILD_WIDTH; i++) begin
         if (!wild[i]) begin
            mask[ADDR_WIDTH-1-OCTET_WIDTH*i -: OCTET_WIDTH] = '1;
         end
      end
      return mask;
   endfunction

endpackage

>>> design/wipf_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the wildcard IP filter table.
// Depends on wipf_pkg for field widths.

interface wipf_req_if import wipf_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [FUNC_WIDTH-1:0]  func;
   logic [OCTET_WIDTH-1:0] octet_a;
   logic [OCTET_WIDTH-1:0] octet_b;
   logic [OCTET_WIDTH-1:0] octet_c;
   logic [OCTET_WIDTH-1:0] octet_d;
   logic [WILD_WIDTH-1:0]  wild_flags;

   modport source (
      output valid, func, octet_a, octet_b, octet_c, octet_d, wild_flags,
      input  ready
   );
   modport sink (
      input  valid, func, octet_a, octet_b, octet_c, octet_d, wild_flags,
      output ready
   );
endinterface

interface wipf_rsp_if import wipf_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic                       success;
   logic                       table_full;
   logic [COUNT_OUT_WIDTH-1:0] entry_count;

   modport source (
      output valid, success, table_full, entry_count,
      input  ready
   );
   modport sink (
      input  valid, success, table_full, entry_count,
      output ready
   );
endinterface

>>> design/wipf_ctrl.sv
`timescale 1ns / 1ps
// Controller of the wildcard IP filter table: sequences capture and commit.
// Depends on wipf_pkg for the command and status structs.

module wipf_ctrl import wipf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= ST_COMMIT;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_COMMIT: begin
               // Wait here while the previous response is still held.
               if (!status.rsp_busy) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready   = req_ready_ff;
   assign cmd.capture = req_valid && req_ready_ff;
   assign cmd.commit  = (state_ff == ST_COMMIT) && !status.rsp_busy;

endmodule

>>> design/wipf_datapath.sv
`timescale 1ns / 1ps
// Datapath of the wildcard IP filter table: entry registers, parallel
// compare, ordered insert and remove, and the response register. Uses wipf_pkg.

module wipf_datapath import wipf_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   input  logic [FUNC_WIDTH-1:0]      req_func,
   input  logic [ADDR_WIDTH-1:0]      req_addr,
   input  logic [WILD_WIDTH-1:0]      req_wild,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_success,
   output logic                       rsp_table_full,
   output logic [COUNT_OUT_WIDTH-1:0] rsp_entry_count
);

   localparam int CNT_WIDTH = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_WIDTH = (CNT_WIDTH > COUNT_OUT_WIDTH) ? CNT_WIDTH : COUNT_OUT_WIDTH;

   logic [ADDR_WIDTH-1:0]      entry_addr_ff [TABLE_DEPTH];
   logic [WILD_WIDTH-1:0]      entry_wild_ff [TABLE_DEPTH];
   logic [CNT_WIDTH-1:0]       count_ff;
   logic [CNT_WIDTH-1:0]       count_in;

   logic [FUNC_WIDTH-1:0]      func_ff;
   logic [ADDR_WIDTH-1:0]      addr_ff;
   logic [WILD_WIDTH-1:0]      wild_ff;
   logic [TABLE_DEPTH-1:0]     exact_hit_ff;
   logic [TABLE_DEPTH-1:0]     exact_hit_in;
   logic [TABLE_DEPTH-1:0]     mask_hit_ff;
   logic [TABLE_DEPTH-1:0]     mask_hit_in;
   logic [TABLE_DEPTH-1:0]     shift_sel;
   logic [ADDR_WIDTH-1:0]      req_care;

   logic                       any_exact;
   logic                       any_mask;
   logic                       is_full;
   logic                       do_write;
   logic                       do_remove;
   logic                       success_in;
   logic                       full_in;
   logic [EXT_WIDTH-1:0]       count_ext;

   logic                       rsp_valid_ff;
   logic                       success_ff;
   logic                       full_ff;
   logic [COUNT_OUT_WIDTH-1:0] count_out_ff;

   // Every occupied slot is compared against the incoming beat at once.
   always_comb begin
      req_care = care_mask(req_wild);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         exact_hit_in[i] = (CNT_WIDTH'(i) < count_ff) && (entry_wild_ff[i] == req_wild) &&
                           (((entry_addr_ff[i] ^ req_addr) & req_care) == '0);
         mask_hit_in[i]  = (CNT_WIDTH'(i) < count_ff) &&
                           (((entry_addr_ff[i] ^ req_addr) & care_mask(entry_wild_ff[i])) == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff      <= req_func;
         addr_ff      <= req_addr;
         wild_ff      <= req_wild;
         exact_hit_ff <= exact_hit_in;
         mask_hit_ff  <= mask_hit_in;
      end
   end

   always_comb begin
      any_exact  = |exact_hit_ff;
      any_mask   = |mask_hit_ff;
      is_full    = (count_ff == CNT_WIDTH'(TABLE_DEPTH));
      // Entries are unique, so at most one exact hit exists; the slots at and
      // above it move down by one on a remove.
      shift_sel  = ~(exact_hit_ff - TABLE_DEPTH'(1));
      success_in = 1'b0;
      full_in    = 1'b0;
      do_write   = 1'b0;
      do_remove  = 1'b0;
      count_in   = count_ff;
      unique case (func_ff)
         FUNC_ADD: begin
            if (!any_exact) begin
               if (is_full) begin
                  full_in = 1'b1;
               end else begin
                  do_write   = 1'b1;
                  count_in   = count_ff + CNT_WIDTH'(1);
                  success_in = 1'b1;
               end
            end
         end
         FUNC_REMOVE: begin
            if (any_exact) begin
               do_remove  = 1'b1;
               count_in   = count_ff - CNT_WIDTH'(1);
               success_in = 1'b1;
            end
         end
         FUNC_CHECK: begin
            success_in = !any_mask;
         end
         default: begin
            success_in = 1'b0;
         end
      endcase
      count_ext = EXT_WIDTH'(count_in);
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_row
      if (i < TABLE_DEPTH - 1) begin : g_shift
         always_ff @(posedge clock) begin
            if (cmd.commit) begin
               if (do_write && (CNT_WIDTH'(i) == count_ff)) begin
                  entry_addr_ff[i] <= addr_ff;
                  entry_wild_ff[i] <= wild_ff;
               end else if (do_remove && shift_sel[i]) begin
                  entry_addr_ff[i] <= entry_addr_ff[i+1];
                  entry_wild_ff[i] <= entry_wild_ff[i+1];
               end
            end
         end
      end else begin : g_last
         always_ff @(posedge clock) begin
            if (cmd.commit && do_write && (CNT_WIDTH'(i) == count_ff)) begin
               entry_addr_ff[i] <= addr_ff;
               entry_wild_ff[i] <= wild_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         count_ff     <= count_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         success_ff   <= success_in;
         full_ff      <= full_in;
         count_out_ff <= count_ext[COUNT_OUT_WIDTH-1:0];
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = success_ff;
   assign rsp_table_full  = full_ff;
   assign rsp_entry_count = count_out_ff;

endmodule

>>> design/wildcard_ip_filter_table.sv
`timescale 1ns / 1ps
// Wildcard IP filter table, top level: wires the controller to the datapath.
// Depends on wipf_pkg, wipf_if, wipf_ctrl and wipf_datapath.
//
// A request beat on req_port carries an operation (add, remove or check), four
// address octets and a wildcard flag per octet. Add appends an entry unless an
// equal entry exists or the table is full; remove deletes the equal entry and
// closes the gap in order; check allows the address unless some entry matches
// it, with wildcard octets matching anything.
// Each request yields exactly one response beat on rsp_port: success,
// table_full and the entry count after the operation.
// The response is registered and turns valid when the update is committed. The
// parallel compare over all entries is captured when a request is accepted, and
// the table update and response write follow. A new request waits for the update.
// The response sits in an output register; a new request may be accepted while
// it waits. If the receiver stalls, the next update waits until the held
// response is taken, and req_port.ready stays low meanwhile.
// Reset clears the entry count, so the table starts empty, and drops any
// pending response. The block is ready in the cycle after reset.

module wildcard_ip_filter_table import wipf_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input logic       clock,
   input logic       reset,
   wipf_req_if.sink   req_port,
   wipf_rsp_if.source rsp_port
);

   dp_cmd_type            cmd;
   dp_status_type         status;
   logic [ADDR_WIDTH-1:0] req_addr;

   assign req_addr = {req_port.octet_a, req_port.octet_b, req_port.octet_c, req_port.octet_d};

   wipf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wipf_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_port.func),
      .req_addr        (req_addr),
      .req_wild        (req_port.wild_flags),
      .rsp_ready       (rsp_port.ready),
      .rsp_valid       (rsp_port.valid),
      .rsp_success     (rsp_port.success),
      .rsp_table_full  (rsp_port.table_full),
      .rsp_entry_count (rsp_port.entry_count)
   );

endmodule

>>> design/wipf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the wildcard IP filter table, bound to the top level.
// Depends on wipf_pkg for field widths.

module wipf_checker import wipf_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_success,
   input logic                       rsp_table_full,
   input logic [COUNT_OUT_WIDTH-1:0] rsp_entry_count
);

   // Reset drops any pending response.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The table works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on two consecutive cycles");

   // A stalled response beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_success) &&
         $stable(rsp_table_full) && $stable(rsp_entry_count))
      else $error("stalled response changed");

   // An add refused for a full table never reports success.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_success)
      else $error("table full reported together with success");

endmodule

bind wildcard_ip_filter_table wipf_checker u_wipf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_success     (rsp_port.success),
   .rsp_table_full  (rsp_port.table_full),
   .rsp_entry_count (rsp_port.entry_count)
);

>>> bench/wipf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the wildcard IP filter table: keeps its own copy of the table,
// predicts every response beat and compares it field by field.
// Depends on wipf_pkg and the channel interfaces in wipf_if.

module wipf_scoreboard import wipf_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   wipf_req_if  req_mon,
   wipf_rsp_if  rsp_mon,
   output int   fail_count,
   output int   outstanding
);

   typedef struct packed {
      logic                       success;
      logic                       table_full;
      logic [COUNT_OUT_WIDTH-1:0] entry_count;
   } verdict_type;

   logic [ADDR_WIDTH-1:0] ban_addr [TABLE_DEPTH];
   logic [WILD_WIDTH-1:0] ban_wild [TABLE_DEPTH];
   int                    ban_total;
   verdict_type           pending_verdicts[$];

   // Octets under a wildcard bit drop out of every compare; octet a is the top byte.
   function automatic logic [ADDR_WIDTH-1:0] octet_keep(input logic [WILD_WIDTH-1:0] wild);
      return {{8{~wild[0]}}, {8{~wild[1]}}, {8{~wild[2]}}, {8{~wild[3]}}};
   endfunction

   // Slot of the first entry with the same mask and the same kept octets, or -1.
   function automatic int find_same_rule(input logic [ADDR_WIDTH-1:0] addr,
                                         input logic [WILD_WIDTH-1:0] wild);
      logic [ADDR_WIDTH-1:0] keep;
      keep = octet_keep(wild);
      for (int i = 0; i < ban_total; i++) begin
         if (ban_wild[i] == wild && (ban_addr[i] & keep) == (addr & keep)) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic verdict_type judge_request(input logic [FUNC_WIDTH-1:0] op,
                                                 input logic [ADDR_WIDTH-1:0] addr,
                                                 input logic [WILD_WIDTH-1:0] wild);
      verdict_type v;
      int          slot;
      v = '0;
      case (op)
         FUNC_ADD: begin
            // A duplicate is refused before the full test is made.
            if (find_same_rule(addr, wild) < 0) begin
               if (ban_total >= TABLE_DEPTH) begin
                  v.table_full = 1'b1;
               end else begin
                  ban_addr[ban_total] = addr;
                  ban_wild[ban_total] = wild;
                  ban_total++;
                  v.success = 1'b1;
               end
            end
         end
         FUNC_REMOVE: begin
            slot = find_same_rule(addr, wild);
            if (slot >= 0) begin
               for (int i = slot; i + 1 < ban_total; i++) begin
                  ban_addr[i] = ban_addr[i+1];
                  ban_wild[i] = ban_wild[i+1];
               end
               ban_total--;
               v.success = 1'b1;
            end
         end
         FUNC_CHECK: begin
            v.success = 1'b1;
            for (int i = 0; i < ban_total; i++) begin
               if ((ban_addr[i] & octet_keep(ban_wild[i])) ==
                   (addr & octet_keep(ban_wild[i]))) begin
                  v.success = 1'b0;
                  break;
               end
            end
         end
         default: ;
      endcase
      v.entry_count = COUNT_OUT_WIDTH'(ban_total);
      return v;
   endfunction

   initial begin
      fail_count  = 0;
      outstanding = 0;
      ban_total   = 0;
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset) begin
         // The response leaving at this edge always belongs to an older request.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_verdicts.size() == 0) begin
               $error("response beat arrived with no request pending");
               fail_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_mon.success !== want.success) begin
                  $error("success: expected %0b, actual %0b", want.success, rsp_mon.success);
                  fail_count++;
               end
               if (rsp_mon.table_full !== want.table_full) begin
                  $error("table_full: expected %0b, actual %0b",
                         want.table_full, rsp_mon.table_full);
                  fail_count++;
               end
               if (rsp_mon.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want.entry_count, rsp_mon.entry_count);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_verdicts.push_back(judge_request(req_mon.func,
               {req_mon.octet_a, req_mon.octet_b, req_mon.octet_c, req_mon.octet_d},
               req_mon.wild_flags));
         end
         outstanding = pending_verdicts.size();
      end
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Top of the filter table bench: clock, reset, request stimulus, response stalls
// and the verdict. Depends on wipf_pkg, wipf_if, the block and wipf_scoreboard.

module testbench import wipf_pkg::*; ;

   localparam int TABLE_DEPTH = 64;
   localparam int ITEM_TARGET = 1400;
   localparam int CALM_ITEMS  = 200;
   localparam int HOLD_AFTER  = 500;
   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SPARE = 2'd3;

   typedef struct {
      logic [ADDR_WIDTH-1:0] addr;
      logic [WILD_WIDTH-1:0] wild;
   } ban_rule_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   sent_total = 0;
   bit   calm = 1'b0;
   bit   hold_request = 1'b0;
   ban_rule_type issued_rules[$];

   wipf_req_if req_bus();
   wipf_rsp_if rsp_bus();

   wildcard_ip_filter_table #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   wipf_scoreboard #(.TABLE_DEPTH(TABLE_DEPTH)) scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Octets lean toward the edges of the range so that rules collide now and then.
   function automatic logic [OCTET_WIDTH-1:0] rand_octet();
      case ($urandom_range(0, 3))
         0:       return OCTET_WIDTH'($urandom_range(0, 3));
         1:       return OCTET_WIDTH'($urandom_range(252, 255));
         default: return OCTET_WIDTH'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [ADDR_WIDTH-1:0] rand_addr();
      return {rand_octet(), rand_octet(), rand_octet(), rand_octet()};
   endfunction

   // Mostly plain rules; a full wildcard would block every check while it stays.
   function automatic logic [WILD_WIDTH-1:0] rand_wild();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return '0;
      if (pick < 8) return WILD_WIDTH'(1) << $urandom_range(0, 3);
      return WILD_WIDTH'($urandom_range(1, 14));
   endfunction

   function automatic logic [ADDR_WIDTH-1:0] scramble_wild_octets(
         input logic [ADDR_WIDTH-1:0] addr, input logic [WILD_WIDTH-1:0] wild);
      for (int i = 0; i < WILD_WIDTH; i++) begin
         if (wild[i]) addr[ADDR_WIDTH-1-OCTET_WIDTH*i -: OCTET_WIDTH] = rand_octet();
      end
      return addr;
   endfunction

   task automatic send_request(input logic [FUNC_WIDTH-1:0] op,
                               input logic [ADDR_WIDTH-1:0] addr,
                               input logic [WILD_WIDTH-1:0] wild);
      req_bus.valid      <= 1'b1;
      req_bus.func       <= op;
      req_bus.octet_a    <= addr[31:24];
      req_bus.octet_b    <= addr[23:16];
      req_bus.octet_c    <= addr[15:8];
      req_bus.octet_d    <= addr[7:0];
      req_bus.wild_flags <= wild;
      do @(posedge clock); while (!req_bus.ready);
      sent_total++;
      calm = (sent_total >= ITEM_TARGET - CALM_ITEMS);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // A new rule is remembered only while the table should still have room.
   task automatic add_new_rule();
      ban_rule_type rule;
      rule.addr = rand_addr();
      rule.wild = rand_wild();
      if (issued_rules.size() < TABLE_DEPTH) issued_rules.push_back(rule);
      send_request(FUNC_ADD, rule.addr, rule.wild);
   endtask

   task automatic add_duplicate_rule();
      ban_rule_type rule;
      if (issued_rules.size() == 0) begin
         add_new_rule();
      end else begin
         rule = issued_rules[$urandom_range(0, issued_rules.size() - 1)];
         send_request(FUNC_ADD, scramble_wild_octets(rule.addr, rule.wild), rule.wild);
      end
   endtask

   task automatic remove_known_rule();
      ban_rule_type rule;
      int           slot;
      if (issued_rules.size() == 0) begin
         send_request(FUNC_REMOVE, rand_addr(), rand_wild());
      end else begin
         slot = $urandom_range(0, issued_rules.size() - 1);
         rule = issued_rules[slot];
         issued_rules.delete(slot);
         send_request(FUNC_REMOVE, scramble_wild_octets(rule.addr, rule.wild), rule.wild);
      end
   endtask

   // Removes that should miss: a random rule, or a known rule under another mask.
   task automatic remove_missing_rule();
      ban_rule_type rule;
      if (issued_rules.size() == 0 || $urandom_range(0, 1) == 0) begin
         send_request(FUNC_REMOVE, rand_addr(), rand_wild());
      end else begin
         rule = issued_rules[$urandom_range(0, issued_rules.size() - 1)];
         send_request(FUNC_REMOVE, rule.addr,
                      rule.wild ^ (WILD_WIDTH'(1) << $urandom_range(0, 3)));
      end
   endtask

   // Checks hit a known rule, miss it by one bit, or use an unrelated address.
   task automatic check_address();
      ban_rule_type          rule;
      logic [ADDR_WIDTH-1:0] addr;
      int                    octet;
      int                    pick;
      pick = $urandom_range(0, 3);
      if (issued_rules.size() == 0 || pick == 0) begin
         addr = rand_addr();
      end else begin
         rule = issued_rules[$urandom_range(0, issued_rules.size() - 1)];
         addr = scramble_wild_octets(rule.addr, rule.wild);
         if (pick == 1 && rule.wild != '1) begin
            do octet = $urandom_range(0, 3); while (rule.wild[octet]);
            addr[ADDR_WIDTH-1-OCTET_WIDTH*octet-$urandom_range(0, 7)] ^= 1'b1;
         end
      end
      send_request(FUNC_CHECK, addr, WILD_WIDTH'($urandom_range(0, 15)));
   endtask

   task automatic fill_and_drain();
      int keep_left;
      while (issued_rules.size() < TABLE_DEPTH) begin
         add_new_rule();
         if ($urandom_range(0, 7) == 0) check_address();
      end
      repeat ($urandom_range(2, 5)) begin
         add_new_rule();
         add_duplicate_rule();
         check_address();
      end
      keep_left = $urandom_range(0, 20);
      while (issued_rules.size() > keep_left) begin
         remove_known_rule();
         if ($urandom_range(0, 2) == 0) check_address();
         if ($urandom_range(0, 9) == 0) remove_missing_rule();
      end
   endtask

   task automatic mixed_traffic();
      int pick;
      repeat (60) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)      add_new_rule();
         else if (pick < 38) add_duplicate_rule();
         else if (pick < 55) remove_known_rule();
         else if (pick < 63) remove_missing_rule();
         else if (pick < 97) check_address();
         else                send_request(FUNC_SPARE, rand_addr(), rand_wild());
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_request) begin
            // The block fills up behind this stall and must drop its request ready.
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      int  episode;
      bit  hold_done;
      reset              = 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= FUNC_ADD;
      req_bus.octet_a    <= '0;
      req_bus.octet_b    <= '0;
      req_bus.octet_c    <= '0;
      req_bus.octet_d    <= '0;
      req_bus.wild_flags <= '0;
      episode   = 0;
      hold_done = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty table: checks allow, removes miss.
      send_request(FUNC_CHECK,  32'h00000000, 4'b0000);
      send_request(FUNC_CHECK,  32'hFFFFFFFF, 4'b1111);
      send_request(FUNC_REMOVE, 32'h01020304, 4'b0000);
      // Extremes and duplicates, including a duplicate that differs only under a wildcard.
      send_request(FUNC_ADD,    32'h00000000, 4'b0000);
      send_request(FUNC_ADD,    32'h00000000, 4'b0000);
      send_request(FUNC_ADD,    32'hFFFFFFFF, 4'b0000);
      send_request(FUNC_ADD,    {8'd10, 8'd77, 8'd3, 8'd4}, 4'b0010);
      send_request(FUNC_ADD,    {8'd10, 8'd99, 8'd3, 8'd4}, 4'b0010);
      send_request(FUNC_ADD,    {8'd10, 8'd99, 8'd3, 8'd4}, 4'b0000);
      // Check matches through the wildcard and ignores its own flags.
      send_request(FUNC_CHECK,  {8'd10, 8'd5, 8'd3, 8'd4}, 4'b0000);
      send_request(FUNC_CHECK,  {8'd10, 8'd5, 8'd3, 8'd5}, 4'b1111);
      send_request(FUNC_REMOVE, {8'd10, 8'd0, 8'd3, 8'd4}, 4'b0010);
      send_request(FUNC_CHECK,  {8'd10, 8'd5, 8'd3, 8'd4}, 4'b0000);
      send_request(FUNC_CHECK,  {8'd10, 8'd99, 8'd3, 8'd4}, 4'b0000);
      // A rule of four wildcards blocks every address.
      send_request(FUNC_ADD,    {8'd1, 8'd2, 8'd3, 8'd4}, 4'b1111);
      send_request(FUNC_CHECK,  {8'd200, 8'd1, 8'd1, 8'd1}, 4'b0000);
      send_request(FUNC_REMOVE, {8'd9, 8'd9, 8'd9, 8'd9}, 4'b1111);
      send_request(FUNC_SPARE,  32'hFFFFFFFF, 4'b1111);
      // Removing the first entry keeps the rest in order.
      send_request(FUNC_REMOVE, 32'h00000000, 4'b0000);
      send_request(FUNC_REMOVE, 32'h00000000, 4'b0000);
      send_request(FUNC_CHECK,  32'hFFFFFFFF, 4'b0000);
      send_request(FUNC_REMOVE, 32'hFFFFFFFF, 4'b0000);
      send_request(FUNC_REMOVE, {8'd10, 8'd99, 8'd3, 8'd4}, 4'b0000);
      send_request(FUNC_CHECK,  32'h00000000, 4'b0000);

      while (sent_total < ITEM_TARGET) begin
         if (!hold_done && sent_total >= HOLD_AFTER) begin
            hold_request = 1'b1;
            hold_done    = 1'b1;
         end
         if (episode % 4 == 1 || $urandom_range(0, 4) == 0) fill_and_drain();
         else mixed_traffic();
         episode++;
      end

      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
